### rtl/fla_pkg.sv
package fla_pkg;

    // Pool geometry.
    localparam int POOL_SLOTS = 16;
    localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

    // Item field widths.
    localparam int SLOT_W    = 4;
    localparam int GRANT_W   = 4;
    localparam int FREE_W    = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EXHAUSTED = 2'd1,
        STS_BAD_INDEX = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    upd_release;  // push the item's slot onto the list
        logic    upd_acquire;  // pop the head using the link read last cycle
        logic    load_out;     // capture a result into the output register
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_empty;
        logic rel_bad;
    } t_dp_sts;

endpackage

### rtl/fla_ram.sv
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/fla_datapath.sv
module fla_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fla_pkg::t_dp_cmd          i_cmd,
    input  logic [fla_pkg::SLOT_W-1:0] i_slot,
    output fla_pkg::t_dp_sts          o_sts,
    output fla_pkg::t_status          o_status,
    output logic [fla_pkg::GRANT_W-1:0] o_granted,
    output logic [fla_pkg::FREE_W-1:0]  o_free
);
    import fla_pkg::*;

    logic [LINK_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [POOL_SLOTS-1:0] r_link_vld;
    logic               r_rd_vld;
    logic [LINK_W-1:0]  rd_link;
    logic [LINK_W-1:0]  next_link;
    logic [IDX_W-1:0]   head_idx;
    logic [IDX_W-1:0]   slot_idx;
    t_status            r_status;
    logic [GRANT_W-1:0] r_granted, n_granted;
    logic [FREE_W-1:0]  r_free;

    assign head_idx = r_head[IDX_W-1:0];
    assign slot_idx = IDX_W'(i_slot);

    assign o_sts.head_empty = (r_head >= LINK_W'(POOL_SLOTS));
    assign o_sts.rel_bad    = (32'(i_slot) >= POOL_SLOTS);

    // The link table reads at the head every cycle; an entry never written
    // since reset is read as its reset link, the next slot up.
    fla_ram #(
        .WIDTH(LINK_W),
        .DEPTH(POOL_SLOTS)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.upd_release),
        .i_wr_addr(slot_idx),
        .i_wr_data(r_head),
        .i_rd_addr(head_idx),
        .o_rd_data(rd_link)
    );

    assign next_link = r_rd_vld ? rd_link : (r_head + LINK_W'(1));

    always_comb begin
        n_head    = r_head;
        n_used    = r_used;
        n_granted = '0;
        if (i_cmd.upd_release) begin
            n_head = LINK_W'(i_slot);
            if (r_used != '0) begin
                n_used = r_used - CNT_W'(1);
            end
        end else if (i_cmd.upd_acquire) begin
            n_head    = next_link;
            n_granted = GRANT_W'(r_head);
            if (r_used < CNT_W'(POOL_SLOTS)) begin
                n_used = r_used + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_used     <= '0;
            r_link_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_used   <= n_used;
            r_rd_vld <= r_link_vld[head_idx];
            if (i_cmd.upd_release) begin
                r_link_vld[slot_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status  <= i_cmd.out_status;
            r_granted <= n_granted;
            r_free    <= FREE_W'(CNT_W'(POOL_SLOTS) - n_used);
        end
    end

    assign o_status  = r_status;
    assign o_granted = r_granted;
    assign o_free    = r_free;

endmodule

### rtl/fla_ctrl.sv
module fla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_opcode,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fla_pkg::t_dp_sts i_sts,
    output fla_pkg::t_dp_cmd o_cmd
);
    import fla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd.upd_release = 1'b0;
        o_cmd.upd_acquire = 1'b0;
        o_cmd.load_out    = 1'b0;
        o_cmd.out_status  = STS_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_ACQUIRE) begin
                        if (i_sts.head_empty) begin
                            o_cmd.load_out   = 1'b1;
                            o_cmd.out_status = STS_EXHAUSTED;
                        end else begin
                            n_state = S_READ;
                        end
                    end else if (i_sts.rel_bad) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = STS_BAD_INDEX;
                    end else begin
                        o_cmd.upd_release = 1'b1;
                        o_cmd.load_out    = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.upd_acquire = 1'b1;
                    o_cmd.load_out    = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### rtl/free_list_slot_allocator_unit.sv
// Free-list slot allocator for a pool of POOL_SLOTS slots.
//
// Requests arrive on the s_axis channel. tuser carries the opcode (acquire
// or release) and tdata carries the slot being returned by a release.
// Results leave on the m_axis channel, exactly one item per request, in
// request order. tuser carries the status (ok, pool exhausted, bad index)
// and tdata carries the granted slot and the count of free slots.
//
// A release or a refused request loads its result at acceptance: the result is in the output
// register on the cycle after the request is accepted. A successful acquire also passes through
// S_READ, because the link of the head slot comes from the link table RAM with a registered read
// before the new head is known. The block works on one request at a time, so releases flow at
// one item per cycle while the receiver keeps up; an acquire ends before the next is taken.
//
// At reset the whole pool is free, the head is slot zero and each slot links to the next. The
// link table is not swept: a valid bit per entry marks entries written since reset, and an
// unwritten entry reads as its reset link. The block is ready as soon as reset is released.
//
// When the receiver stalls, the result holds in the output register and the
// block accepts one more request only once that register can be reloaded.
module free_list_slot_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [fla_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // [3:0] release_slot
    input  logic                             i_s_axis_tuser,  // [0] opcode
    // Result channel.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [fla_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,  // [3:0] granted_slot,
                                                              // [8:4] free_slots
    output logic [1:0]                       o_m_axis_tuser   // [1:0] status
);
    import fla_pkg::*;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    t_status            status;
    logic [GRANT_W-1:0] granted;
    logic [FREE_W-1:0]  free_cnt;

    // The controller sequences each request and owns the result valid flag.
    fla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_opcode   (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the head, the used count, the link table and the
    // result payload.
    fla_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_slot   (i_s_axis_tdata[SLOT_W-1:0]),
        .o_sts    (sts),
        .o_status (status),
        .o_granted(granted),
        .o_free   (free_cnt)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - GRANT_W - FREE_W){1'b0}}, free_cnt, granted};
    assign o_m_axis_tuser = status;

endmodule

### tb/tb_free_list_slot_allocator_unit.sv
module tb_free_list_slot_allocator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fla_pkg::*;

    // Cycles without any handshake on either channel before the run is declared hung.
    // The longest legal quiet spell is the receiver hold-off below, well under this.
    localparam int STALL_LIMIT    = 2000;
    // Random requests issued while the list is kept consistent.
    localparam int CLEAN_ITEMS    = 1650;
    // Requests with arbitrary slots issued at the very end, double releases included.
    localparam int NOISE_ITEMS    = 120;
    // The receiver stops taking results for this many cycles once, mid-run.
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AFTER  = 300;

    // One result as the block should report it.
    typedef struct packed {
        t_status              status;
        logic [GRANT_W-1:0]   grant;
        logic [FREE_W-1:0]    free_cnt;
    } t_reply;

    // Tracks the free list the block should be holding, and the results that
    // accepted requests still owe. Slots currently handed out are kept too,
    // so that the stimulus can return slots that were really granted.
    class pool_tracker;
        logic [LINK_W-1:0] next_free [POOL_SLOTS];
        logic [LINK_W-1:0] head;
        logic [CNT_W-1:0]  in_use;
        t_reply            replies [$];
        logic [IDX_W-1:0]  held_slots [$];
        int                errors;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++)
                next_free[i] = LINK_W'(i + 1);
            head   = '0;
            in_use = '0;
            errors = 0;
        endfunction

        // Apply one accepted request to the list and queue the result it owes.
        function void note_request(logic op, logic [SLOT_W-1:0] slot);
            t_reply r;
            r.status = STS_OK;
            r.grant  = '0;
            if (op == OP_ACQUIRE) begin
                if (head >= POOL_SLOTS) begin
                    r.status = STS_EXHAUSTED;
                end else begin
                    r.grant = GRANT_W'(head);
                    held_slots.push_back(IDX_W'(head));
                    head = next_free[head[IDX_W-1:0]];
                    if (in_use < POOL_SLOTS)
                        in_use++;
                end
            end else if (slot >= POOL_SLOTS) begin
                r.status = STS_BAD_INDEX;
            end else begin
                next_free[slot] = head;
                head = LINK_W'(slot);
                if (in_use > 0)
                    in_use--;
                for (int i = 0; i < held_slots.size(); i++) begin
                    if (held_slots[i] == slot) begin
                        held_slots.delete(i);
                        break;
                    end
                end
            end
            r.free_cnt = FREE_W'(POOL_SLOTS - in_use);
            replies.push_back(r);
        endfunction

        // Compare one result from the block with the oldest one owed.
        function void check_result(logic [1:0] status, logic [GRANT_W-1:0] grant,
                                   logic [FREE_W-1:0] free_cnt);
            t_reply r;
            if (replies.size() == 0) begin
                $error("result with none owed: status %0d, granted_slot %0d, free_slots %0d",
                       status, grant, free_cnt);
                errors++;
                return;
            end
            r = replies.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
            if (grant !== r.grant) begin
                $error("granted_slot: expected %0d, actual %0d", r.grant, grant);
                errors++;
            end
            if (free_cnt !== r.free_cnt) begin
                $error("free_slots: expected %0d, actual %0d", r.free_cnt, free_cnt);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [S_TDATA_W-1:0]   s_data    = '0;   // [3:0] release_slot
    logic                   s_user    = 1'b0; // [0] opcode
    logic                   m_ready   = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [M_TDATA_W-1:0]   m_data;           // [3:0] granted_slot, [8:4] free_slots
    logic [1:0]             m_user;           // [1:0] status

    pool_tracker book = new();

    // Set by the sender while both sides should run without any idling.
    bit steady = 1'b0;
    // Requests accepted so far; the receiver uses it to time its hold-off.
    int sent = 0;
    int quiet_cycles = 0;

    free_list_slot_allocator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Present one request and hold it until the block takes it. The request
    // is booked in the tracker at the edge where it is accepted. Afterwards,
    // outside the steady stretch, the sender may drop valid for a random gap;
    // otherwise the next call keeps valid high straight into the following item.
    task automatic offer(input logic op, input logic [SLOT_W-1:0] slot);
        int gap;
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= S_TDATA_W'(slot);
        do
            @(posedge i_clk);
        while (!s_ready);
        book.note_request(op, slot);
        sent++;
        if (!steady && $urandom_range(99) < 32) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Return one of the slots currently handed out, picked at random.
    task automatic return_held();
        logic [SLOT_W-1:0] slot;
        slot = book.held_slots[$urandom_range(book.held_slots.size() - 1)];
        offer(OP_RELEASE, slot);
    endtask

    // Result side: takes results with random stalls, runs flat out during
    // the steady stretch, and once holds off for a long time so that the
    // output register fills and the block has to refuse new requests.
    initial begin
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && sent >= HOLD_OFF_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                held_off = 1'b1;
            end
            m_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    // Every result that crosses the output handshake is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            book.check_result(m_user, m_data[GRANT_W-1:0], m_data[GRANT_W +: FREE_W]);
    end

    // A hang on either channel ends the run as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL free_list_slot_allocator_unit");
            $finish;
        end
    end

    initial begin
        int bias;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drain the whole pool: the grants walk the reset list from the lowest
        // slot to the highest and the free count falls to zero.
        repeat (POOL_SLOTS) offer(OP_ACQUIRE, '0);
        // An acquire on an empty list is refused as exhausted.
        offer(OP_ACQUIRE, '0);
        // Return slots out of order, the highest and lowest among them, then
        // pop two back off the head: last returned comes out first.
        offer(OP_RELEASE, 4'd15);
        offer(OP_RELEASE, 4'd0);
        offer(OP_RELEASE, 4'd10);
        offer(OP_ACQUIRE, '0);
        offer(OP_ACQUIRE, '0);

        // Well-formed traffic: only slots really held are returned. The mix of
        // acquires and releases shifts every 40 items, so the pool swings
        // between nearly full, nearly empty and exhausted many times.
        bias = 50;
        for (int n = 0; n < CLEAN_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       bias = 15;
                    1:       bias = 50;
                    default: bias = 85;
                endcase
            end
            steady = (n >= 800 && n < 1100);
            if (book.held_slots.size() == 0 || $urandom_range(99) < bias)
                offer(OP_ACQUIRE, '0);
            else
                return_held();
        end
        steady = 1'b0;

        // Give everything back so the whole pool is free again.
        while (book.held_slots.size() != 0)
            return_held();

        // From here on the list can be corrupted on purpose. A release with
        // nothing in use is a double release and must leave the used count
        // at zero. Arbitrary releases and a heavy acquire mix then loop the
        // list on itself, which also drives the used count up to the full pool.
        offer(OP_RELEASE, 4'd7);
        for (int n = 0; n < NOISE_ITEMS; n++) begin
            if ($urandom_range(99) < 70)
                offer(OP_ACQUIRE, SLOT_W'($urandom_range(15)));
            else
                offer(OP_RELEASE, SLOT_W'($urandom_range(15)));
        end
        s_valid <= 1'b0;

        // Wait for every owed result, then idle on to catch any stray result.
        while (book.replies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (book.errors == 0)
            $display("PASS free_list_slot_allocator_unit");
        else
            $display("FAIL free_list_slot_allocator_unit");
        $finish;
    end

endmodule
